/* rtl/lps_pkg.sv */
// Shared types, constants and register codes of the LED pattern sequencer.
package lps_pkg;

    localparam int LED_COUNT = 8;
    localparam int POS_W     = $clog2(LED_COUNT);
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int BTN_COUNT = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_BASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_BASE    = 3'd4;

    localparam logic [CFG_W-1:0] SLOW_PERIOD_RST = 16'd1000;
    localparam logic [CFG_W-1:0] FAST_PERIOD_RST = 16'd500;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;
    localparam logic [CFG_W-1:0] DISP_BASE_RST   = 16'd100;
    localparam logic [CFG_W-1:0] GAP_BASE_RST    = 16'd100;

    localparam int BTN_SPEED  = 0;
    localparam int BTN_MODE_A = 1;
    localparam int BTN_MODE_C = 3;

    typedef logic [LED_COUNT-1:0] t_leds;

    typedef enum logic [1:0] {
        MODE_BOUNCE  = 2'd0,
        MODE_INVERT  = 2'd1,
        MODE_SPARKLE = 2'd2,
        MODE_DARK    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_DISPLAY = 3'b010,
        PH_OFF     = 3'b100
    } t_phase;

    typedef struct packed {
        logic [CFG_W-1:0] slow_period;
        logic [CFG_W-1:0] fast_period;
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] display_base;
        logic [CFG_W-1:0] off_gap_base;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  buttons;
        logic [7:0]  random_pattern;
        logic [10:0] display_extra;
        logic [5:0]  gap_extra;
    } t_in_item;

    typedef struct packed {
        t_leds leds;
        t_mode active_mode;
    } t_result;

endpackage

/* rtl/lps_ifs.sv */
// Handshake interfaces for the input, result and configuration channels.
interface lps_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  buttons;
    logic [7:0]  random_pattern;
    logic [10:0] display_extra;
    logic [5:0]  gap_extra;

    modport source (output valid, buttons, random_pattern, display_extra, gap_extra,
                    input ready);
    modport sink (input valid, buttons, random_pattern, display_extra, gap_extra,
                  output ready);
endinterface

interface lps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] leds;
    logic [1:0] active_mode;

    modport source (output valid, leds, active_mode, input ready);
    modport sink (input valid, leds, active_mode, output ready);
endinterface

interface lps_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/lps_cfg_regs.sv */
// Configuration register file of the LED pattern sequencer.
module lps_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [lps_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [lps_pkg::CFG_W-1:0]    i_wr_data,
    output lps_pkg::t_cfg                o_cfg
);
    import lps_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow_period    <= SLOW_PERIOD_RST;
            r_cfg.fast_period    <= FAST_PERIOD_RST;
            r_cfg.debounce_ticks <= DEBOUNCE_RST;
            r_cfg.display_base   <= DISP_BASE_RST;
            r_cfg.off_gap_base   <= GAP_BASE_RST;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_SLOW_PERIOD: r_cfg.slow_period    <= i_wr_data;
                CFG_FAST_PERIOD: r_cfg.fast_period    <= i_wr_data;
                CFG_DEBOUNCE:    r_cfg.debounce_ticks <= i_wr_data;
                CFG_DISP_BASE:   r_cfg.display_base   <= i_wr_data;
                CFG_GAP_BASE:    r_cfg.off_gap_base   <= i_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/lps_core.sv */
// Per-tick state update: period counter, button handling and LED modes.
module lps_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  lps_pkg::t_cfg     i_cfg,
    input  lps_pkg::t_in_item i_item,
    output lps_pkg::t_result  o_result
);
    import lps_pkg::*;

    logic [TIME_W-1:0] r_tick, n_tick;
    logic [CFG_W-1:0]  r_count, n_count;
    logic              r_step, n_step;
    logic              r_fast, n_fast;
    logic [TIME_W-1:0] r_last [BTN_COUNT];
    logic [TIME_W-1:0] n_last [BTN_COUNT];
    logic [3:0]        r_prev, n_prev;
    t_mode             r_mode, n_mode;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_up, n_up;
    t_phase            r_phase, n_phase;
    logic [TIME_W-1:0] r_disp_end, n_disp_end;
    logic [TIME_W-1:0] r_next_off, n_next_off;
    t_leds             r_leds, n_leds;

    logic [CFG_W-1:0]  period;
    logic [TIME_W-1:0] gap;
    t_leds             one_hot;

    // A time mark counts as reached when it lies less than half the counter range behind.
    function automatic logic time_reached(input logic [TIME_W-1:0] now,
                                          input logic [TIME_W-1:0] mark);
        logic [TIME_W-1:0] diff;
        diff = now - mark;
        return !diff[TIME_W-1];
    endfunction

    always_comb begin
        n_tick     = r_tick + TIME_W'(1);
        n_count    = r_count;
        n_step     = r_step;
        n_fast     = r_fast;
        n_last     = r_last;
        n_prev     = i_item.buttons;
        n_mode     = r_mode;
        n_pos      = r_pos;
        n_up       = r_up;
        n_phase    = r_phase;
        n_disp_end = r_disp_end;
        n_next_off = r_next_off;
        n_leds     = r_leds;

        period = r_fast ? i_cfg.fast_period : i_cfg.slow_period;
        gap    = TIME_W'(i_cfg.off_gap_base) + TIME_W'(i_item.gap_extra);
        if (({1'b0, r_count} + 17'd1) >= {1'b0, period}) begin
            n_step  = 1'b1;
            n_count = '0;
        end else begin
            n_count = r_count + CFG_W'(1);
        end

        for (int b = 0; b < BTN_COUNT; b++) begin
            if (r_prev[b] && !i_item.buttons[b] &&
                ((n_tick - r_last[b]) > TIME_W'(i_cfg.debounce_ticks))) begin
                n_last[b] = n_tick;
                if (b == BTN_SPEED) begin
                    n_fast  = !n_fast;
                    n_count = '0;
                end else begin
                    n_mode  = t_mode'(2'(b - BTN_MODE_A));
                    n_phase = PH_IDLE;
                    n_leds  = '0;
                    if (b != BTN_MODE_C) begin
                        n_pos = '0;
                        n_up  = 1'b1;
                    end
                end
            end
        end

        one_hot = t_leds'(1) << n_pos;
        unique case (n_mode)
            MODE_BOUNCE, MODE_INVERT: begin
                if (n_step) begin
                    n_leds = (n_mode == MODE_BOUNCE) ? one_hot : ~one_hot;
                    n_step = 1'b0;
                    if (n_up) begin
                        if (n_pos < POS_W'(LED_COUNT - 1)) begin
                            n_pos = n_pos + POS_W'(1);
                        end else begin
                            n_up  = 1'b0;
                            n_pos = POS_W'(LED_COUNT - 2);
                        end
                    end else begin
                        if (n_pos != '0) begin
                            n_pos = n_pos - POS_W'(1);
                        end else begin
                            n_up  = 1'b1;
                            n_pos = POS_W'(1);
                        end
                    end
                end
            end
            MODE_SPARKLE: begin
                if (n_phase == PH_IDLE && n_step) begin
                    n_step = 1'b0;
                    n_leds = i_item.random_pattern[LED_COUNT-1:0];
                    if (n_leds != '0) begin
                        n_disp_end = n_tick + TIME_W'(i_cfg.display_base)
                                     + TIME_W'(i_item.display_extra);
                        n_phase    = PH_DISPLAY;
                    end
                end
                if (n_phase != PH_IDLE) begin
                    n_step = 1'b0;
                end
                if (n_phase == PH_DISPLAY && time_reached(n_tick, n_disp_end)) begin
                    n_phase    = PH_OFF;
                    n_next_off = n_tick;
                end
                if (n_phase == PH_OFF && time_reached(n_tick, n_next_off)) begin
                    if (gap == '0) begin
                        n_leds = '0;
                    end else begin
                        n_leds = n_leds & (n_leds - t_leds'(1));
                    end
                    n_next_off = n_tick + gap;
                    if (n_leds == '0) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            MODE_DARK: begin
                n_leds = '0;
                n_step = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_count    <= '0;
            r_step     <= 1'b0;
            r_fast     <= 1'b0;
            r_last     <= '{default: '0};
            r_prev     <= '1;
            r_mode     <= MODE_DARK;
            r_pos      <= '0;
            r_up       <= 1'b1;
            r_phase    <= PH_IDLE;
            r_disp_end <= '0;
            r_next_off <= '0;
            r_leds     <= '0;
        end else if (i_fire) begin
            r_tick     <= n_tick;
            r_count    <= n_count;
            r_step     <= n_step;
            r_fast     <= n_fast;
            r_last     <= n_last;
            r_prev     <= n_prev;
            r_mode     <= n_mode;
            r_pos      <= n_pos;
            r_up       <= n_up;
            r_phase    <= n_phase;
            r_disp_end <= n_disp_end;
            r_next_off <= n_next_off;
            r_leds     <= n_leds;
        end
    end

    assign o_result.leds        = n_leds;
    assign o_result.active_mode = n_mode;

endmodule

/* rtl/led_pattern_sequencer_top.sv */
// Top level of the LED pattern sequencer: input register, core and result register.
// An input beat passes the input register and the core into the result register.
// Throughput: one input beat per cycle while the result side keeps taking beats.
// Under backpressure the result register holds; the input register stalls once full.
// Reset: i_rst_n is synchronous and active low; it restores the default registers,
// mode off with all LEDs dark, and empties both registers.
module led_pattern_sequencer_top (
    input logic        i_clk,
    input logic        i_rst_n,
    lps_in_if.sink     i_in,
    lps_out_if.source  o_out,
    lps_cfg_if.sink    i_cfg
);
    import lps_pkg::*;

    t_cfg     cfg;
    t_result  result;
    logic     advance;
    logic     fire;
    logic     r_in_valid;
    t_in_item r_in_item;
    logic     r_out_valid;
    t_result  r_out;

    assign i_cfg.ready = 1'b1;

    lps_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    assign advance    = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item.buttons        <= i_in.buttons;
            r_in_item.random_pattern <= i_in.random_pattern;
            r_in_item.display_extra  <= i_in.display_extra;
            r_in_item.gap_extra      <= i_in.gap_extra;
        end
    end

    lps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_cfg    (cfg),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.leds        = r_out.leds;
    assign o_out.active_mode = r_out.active_mode;

endmodule

/* tb/tb_led_pattern_sequencer_top.sv */
// Self-checking testbench for the LED pattern sequencer: directed table, then random phases.
module tb_led_pattern_sequencer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lps_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASES      = 7;
    localparam int PHASE_TICKS = 97;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        t_in_item             stim;
        logic                 fixed;
        t_result              want;
    } t_row;

    // Rows before the first register write run on the reset settings, where the
    // debounce time swallows every early press.
    localparam t_row DIRECTED_ROWS [31] = '{
        '{1'b0, '0, '0, '{4'hF, 8'h00, 11'd0, 6'd0}, 1'b1, '{8'h00, MODE_DARK}},
        '{1'b0, '0, '0, '{4'h0, 8'hFF, 11'd1400, 6'd50}, 1'b1, '{8'h00, MODE_DARK}},
        '{1'b0, '0, '0, '{4'hF, 8'h00, 11'd0, 6'd0}, 1'b1, '{8'h00, MODE_DARK}},
        '{1'b0, '0, '0, '{4'hD, 8'h00, 11'd0, 6'd0}, 1'b1, '{8'h00, MODE_DARK}},
        '{1'b1, CFG_SLOW_PERIOD, 16'd1, '0, 1'b0, '0},
        '{1'b1, CFG_FAST_PERIOD, 16'd2, '0, 1'b0, '0},
        '{1'b1, CFG_DEBOUNCE, 16'd0, '0, 1'b0, '0},
        '{1'b1, CFG_DISP_BASE, 16'd0, '0, 1'b0, '0},
        '{1'b1, CFG_GAP_BASE, 16'd0, '0, 1'b0, '0},
        '{1'b1, CFG_UNUSED, 16'hFFFF, '0, 1'b0, '0},
        '{1'b0, '0, '0, '{4'hF, 8'h00, 11'd0, 6'd0}, 1'b1, '{8'h00, MODE_DARK}},
        '{1'b0, '0, '0, '{4'hD, 8'h00, 11'd0, 6'd0}, 1'b1, '{8'h01, MODE_BOUNCE}},
        '{1'b0, '0, '0, '{4'hF, 8'h00, 11'd0, 6'd0}, 1'b1, '{8'h02, MODE_BOUNCE}},
        '{1'b0, '0, '0, '{4'hB, 8'h00, 11'd0, 6'd0}, 1'b1, '{8'hFE, MODE_INVERT}},
        '{1'b0, '0, '0, '{4'hF, 8'h00, 11'd0, 6'd0}, 1'b1, '{8'hFD, MODE_INVERT}},
        '{1'b0, '0, '0, '{4'h7, 8'h00, 11'd0, 6'd0}, 1'b1, '{8'h00, MODE_SPARKLE}},
        '{1'b0, '0, '0, '{4'hF, 8'hA5, 11'd0, 6'd0}, 1'b1, '{8'h00, MODE_SPARKLE}},
        '{1'b0, '0, '0, '{4'hE, 8'h81, 11'd5, 6'd3}, 1'b0, '0},
        '{1'b0, '0, '0, '{4'hF, 8'h3C, 11'd0, 6'd3}, 1'b0, '0},
        '{1'b0, '0, '0, '{4'hF, 8'h55, 11'd7, 6'd3}, 1'b0, '0},
        '{1'b0, '0, '0, '{4'hF, 8'hAA, 11'd0, 6'd3}, 1'b0, '0},
        '{1'b0, '0, '0, '{4'hF, 8'h0F, 11'd2, 6'd3}, 1'b0, '0},
        '{1'b0, '0, '0, '{4'hF, 8'hF0, 11'd0, 6'd3}, 1'b0, '0},
        '{1'b0, '0, '0, '{4'hF, 8'h01, 11'd9, 6'd3}, 1'b0, '0},
        '{1'b0, '0, '0, '{4'hF, 8'h80, 11'd0, 6'd3}, 1'b0, '0},
        '{1'b0, '0, '0, '{4'hF, 8'hFF, 11'd0, 6'd3}, 1'b0, '0},
        '{1'b1, CFG_FAST_PERIOD, 16'd0, '0, 1'b0, '0},
        '{1'b0, '0, '0, '{4'hD, 8'h00, 11'd0, 6'd0}, 1'b1, '{8'h01, MODE_BOUNCE}},
        '{1'b0, '0, '0, '{4'hF, 8'h00, 11'd0, 6'd0}, 1'b1, '{8'h02, MODE_BOUNCE}},
        '{1'b0, '0, '0, '{4'h0, 8'hFF, 11'd2, 6'd50}, 1'b0, '0},
        '{1'b0, '0, '0, '{4'hF, 8'h00, 11'd0, 6'd0}, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic take_ready = 1'b0;

    lps_in_if  in_bus ();
    lps_out_if out_bus ();
    lps_cfg_if cfg_bus ();

    led_pattern_sequencer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    assign out_bus.ready = take_ready;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_cfg cfg_now = '{SLOW_PERIOD_RST, FAST_PERIOD_RST, DEBOUNCE_RST, DISP_BASE_RST,
                      GAP_BASE_RST};

    logic [TIME_W-1:0] tick_cnt = '0;
    logic [CFG_W-1:0]  period_cnt = '0;
    logic              step_due = 1'b0;
    logic              fast_sel = 1'b0;
    logic [TIME_W-1:0] last_press [BTN_COUNT] = '{default: '0};
    logic [3:0]        prev_btn = 4'hF;
    t_mode             cur_mode = MODE_DARK;
    logic [POS_W-1:0]  pos = '0;
    logic              going_up = 1'b1;
    t_phase            sparkle_ph = PH_IDLE;
    logic [TIME_W-1:0] disp_end = '0;
    logic [TIME_W-1:0] next_off = '0;
    logic [3:0]        off_idx = '0;
    logic [3:0]        lit_cnt = '0;
    logic [POS_W-1:0]  lit_pos [LED_COUNT];
    t_leds             led_now = '0;

    t_result frames_due [$];
    int      errors_seen = 0;
    int      quiet_cycles = 0;
    int      burst_left = 0;
    logic [15:0] stall_pat = 16'hFFFF;
    int          pat_age = 0;

    function automatic logic time_reached(input logic [TIME_W-1:0] now,
                                          input logic [TIME_W-1:0] mark);
        logic [TIME_W-1:0] diff;
        diff = now - mark;
        return !diff[TIME_W-1];
    endfunction

    function automatic t_result advance_sequencer(input t_in_item stim);
        logic [TIME_W-1:0] now;
        logic [CFG_W-1:0]  period;
        t_result           res;
        int                b;
        int                i;
        tick_cnt = tick_cnt + 1;
        now = tick_cnt;
        period = fast_sel ? cfg_now.fast_period : cfg_now.slow_period;
        if (({1'b0, period_cnt} + 17'd1) >= {1'b0, period}) begin
            step_due = 1'b1;
            period_cnt = '0;
        end else begin
            period_cnt = period_cnt + 1'b1;
        end
        for (b = 0; b < BTN_COUNT; b++) begin
            if (prev_btn[b] && !stim.buttons[b]
                    && (now - last_press[b]) > TIME_W'(cfg_now.debounce_ticks)) begin
                last_press[b] = now;
                if (b == BTN_SPEED) begin
                    fast_sel = !fast_sel;
                    period_cnt = '0;
                end else begin
                    cur_mode = t_mode'(2'(b - BTN_MODE_A));
                    if (b != BTN_MODE_C) begin
                        pos = '0;
                        going_up = 1'b1;
                    end
                    sparkle_ph = PH_IDLE;
                    led_now = '0;
                end
            end
        end
        prev_btn = stim.buttons;
        case (cur_mode)
            MODE_BOUNCE, MODE_INVERT: begin
                if (step_due) begin
                    led_now = t_leds'(1) << pos;
                    if (cur_mode == MODE_INVERT) begin
                        led_now = ~led_now;
                    end
                    if (going_up) begin
                        if (pos < POS_W'(LED_COUNT - 1)) begin
                            pos = pos + 1'b1;
                        end else begin
                            going_up = 1'b0;
                            pos = POS_W'(LED_COUNT - 2);
                        end
                    end else if (pos > 0) begin
                        pos = pos - 1'b1;
                    end else begin
                        going_up = 1'b1;
                        pos = POS_W'(1);
                    end
                    step_due = 1'b0;
                end
            end
            MODE_SPARKLE: begin
                if (sparkle_ph == PH_IDLE && step_due) begin
                    step_due = 1'b0;
                    led_now = stim.random_pattern;
                    lit_cnt = '0;
                    for (i = 0; i < LED_COUNT; i++) begin
                        if (led_now[i]) begin
                            lit_pos[lit_cnt[POS_W-1:0]] = POS_W'(i);
                            lit_cnt = lit_cnt + 1'b1;
                        end
                    end
                    if (lit_cnt != 0) begin
                        disp_end = now + TIME_W'(cfg_now.display_base)
                                   + TIME_W'(stim.display_extra);
                        sparkle_ph = PH_DISPLAY;
                    end
                end
                if (sparkle_ph != PH_IDLE) begin
                    step_due = 1'b0;
                    if (sparkle_ph == PH_DISPLAY && time_reached(now, disp_end)) begin
                        off_idx = '0;
                        next_off = now;
                        sparkle_ph = PH_OFF;
                    end
                    if (sparkle_ph == PH_OFF) begin
                        while (off_idx < lit_cnt && time_reached(now, next_off)) begin
                            led_now[lit_pos[off_idx[POS_W-1:0]]] = 1'b0;
                            off_idx = off_idx + 1'b1;
                            if (off_idx < lit_cnt) begin
                                next_off = now + TIME_W'(cfg_now.off_gap_base)
                                           + TIME_W'(stim.gap_extra);
                            end
                        end
                        if (off_idx >= lit_cnt) begin
                            sparkle_ph = PH_IDLE;
                        end
                    end
                end
            end
            default: begin
                led_now = '0;
                step_due = 1'b0;
            end
        endcase
        res.leds = led_now;
        res.active_mode = cur_mode;
        return res;
    endfunction

    task automatic send_tick(input t_in_item stim, input logic fixed, input t_result want);
        int      gap;
        t_result predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_bus.valid          <= 1'b1;
        in_bus.buttons        <= stim.buttons;
        in_bus.random_pattern <= stim.random_pattern;
        in_bus.display_extra  <= stim.display_extra;
        in_bus.gap_extra      <= stim.gap_extra;
        do @(posedge i_clk); while (!in_bus.ready);
        predicted = advance_sequencer(stim);
        frames_due.push_back(fixed ? want : predicted);
        burst_left--;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            CFG_SLOW_PERIOD: cfg_now.slow_period = val;
            CFG_FAST_PERIOD: cfg_now.fast_period = val;
            CFG_DEBOUNCE:    cfg_now.debounce_ticks = val;
            CFG_DISP_BASE:   cfg_now.display_base = val;
            CFG_GAP_BASE:    cfg_now.off_gap_base = val;
            default: ;
        endcase
    endtask

    task automatic wait_quiet();
        in_bus.valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (pat_age == 0) begin
            stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
            pat_age <= 64;
        end else begin
            stall_pat <= {stall_pat[14:0], stall_pat[15]};
            pat_age <= pat_age - 1;
        end
        take_ready <= stall_pat[15];
    end

    always @(posedge i_clk) begin
        t_result due;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (frames_due.size() == 0) begin
                $error("result beat with nothing expected: leds %h, active_mode %0d",
                       out_bus.leds, out_bus.active_mode);
                errors_seen++;
            end else begin
                due = frames_due.pop_front();
                if (out_bus.leds !== due.leds) begin
                    $error("leds: expected %h, actual %h", due.leds, out_bus.leds);
                    errors_seen++;
                end
                if (out_bus.active_mode !== due.active_mode) begin
                    $error("active_mode: expected %0d, actual %0d",
                           due.active_mode, out_bus.active_mode);
                    errors_seen++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_row     row;
        t_cfg     setting;
        t_in_item stim;
        logic     prev_cfg;
        int       r;
        int       ph;
        int       k;
        in_bus.valid          = 1'b0;
        in_bus.buttons        = 4'hF;
        in_bus.random_pattern = '0;
        in_bus.display_extra  = '0;
        in_bus.gap_extra      = '0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = '0;
        cfg_bus.data          = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        prev_cfg = 1'b0;
        foreach (DIRECTED_ROWS[n]) begin
            row = DIRECTED_ROWS[n];
            if (row.is_cfg) begin
                if (!prev_cfg) begin
                    wait_quiet();
                end
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                if (prev_cfg) begin
                    cfg_bus.valid <= 1'b0;
                end
                send_tick(row.stim, row.fixed, row.want);
            end
            prev_cfg = row.is_cfg;
        end

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: setting = '{16'd2, 16'd1, 16'd0, 16'd0, 16'd0};
                1: setting = '{16'd0, 16'd3, 16'd3, 16'd4, 16'd1};
                2: setting = '{16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                default: setting = '{16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                                     16'($urandom_range(0, 5)), 16'($urandom_range(0, 12)),
                                     16'($urandom_range(0, 4))};
            endcase
            wait_quiet();
            write_reg(CFG_SLOW_PERIOD, setting.slow_period);
            write_reg(CFG_FAST_PERIOD, setting.fast_period);
            write_reg(CFG_DEBOUNCE, setting.debounce_ticks);
            write_reg(CFG_DISP_BASE, setting.display_base);
            write_reg(CFG_GAP_BASE, setting.off_gap_base);
            if ($urandom_range(0, 1) == 0) begin
                write_reg(CFG_UNUSED, 16'($urandom));
            end
            cfg_bus.valid <= 1'b0;

            for (k = 0; k < PHASE_TICKS; k++) begin
                r = $urandom_range(0, 99);
                stim.buttons = 4'hF;
                if (r < 4) begin
                    stim.buttons[$urandom_range(0, 3)] = 1'b0;
                end else if (r < 6) begin
                    stim.buttons = 4'($urandom);
                end
                r = $urandom_range(0, 7);
                stim.random_pattern = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
                stim.display_extra = ($urandom_range(0, 9) == 0)
                                     ? 11'($urandom_range(0, 1400)) : 11'($urandom_range(0, 6));
                stim.gap_extra = ($urandom_range(0, 9) == 0)
                                 ? 6'($urandom_range(0, 50)) : 6'($urandom_range(0, 3));
                if ($urandom_range(0, 149) == 0) begin
                    wait_quiet();
                end
                send_tick(stim, 1'b0, '0);
            end
        end

        wait_quiet();
        repeat (6) @(posedge i_clk);
        if (errors_seen == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/lps_pkg.sv
rtl/lps_ifs.sv
rtl/lps_cfg_regs.sv
rtl/lps_core.sv
rtl/led_pattern_sequencer_top.sv
tb/tb_led_pattern_sequencer_top.sv
